@@ hw/rtl/fpm_pkg.sv @@
// ----------------------------------------------------------------------------
// fpm_pkg: shared types and constants for the binary32 multiplier
// Field widths, exponent bias, channel payloads and the per-stage record
// passed between cells.
// ----------------------------------------------------------------------------
`default_nettype none
package fpm_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned SigW = FracW + 1;
  localparam int unsigned ProdW = 2 * SigW;
  localparam int unsigned ExpSumW = ExpW + 2;
  localparam logic [ExpSumW-1:0] ExpBias = ExpSumW'(127);
  localparam logic [ExpSumW-1:0] ExpLimit = ExpSumW'(255);
  localparam logic [ExpW-1:0] ExpMax = '1;
  localparam int unsigned NumCells = 3;
  localparam int unsigned StageW = 2;

  typedef enum logic [StageW-1:0] {
    STEP_MUL  = 2'd0,
    STEP_NORM = 2'd1,
    STEP_PACK = 2'd2
  } step_t;

  typedef struct packed {
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
  } mul_req_t;

  typedef struct packed {
    logic [WordW-1:0] product;
    logic             overflow;
    logic             underflow;
  } mul_res_t;

  typedef struct packed {
    logic                 sign;
    logic                 zero;
    logic [ExpSumW-1:0]   exp_sum;
    logic [SigW-1:0]      sig_a;
    logic [SigW-1:0]      sig_b;
    logic [ProdW-1:0]     prod;
    logic [FracW-1:0]     frac;
    logic [WordW-1:0]     product;
    logic                 overflow;
    logic                 underflow;
  } fpm_data_t;
endpackage
`default_nettype wire

@@ hw/rtl/fpm_stream_if.sv @@
// ----------------------------------------------------------------------------
// fpm_stream_if: valid/ready channel with a generic payload
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface fpm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fpm_cell.sv @@
// ----------------------------------------------------------------------------
// fpm_cell: one pipeline cell of the multiplier chain
// Holds one item; performs the step chosen by its position and hands on.
// ----------------------------------------------------------------------------
`default_nettype none
module fpm_cell #(
  parameter fpm_pkg::step_t Step = fpm_pkg::STEP_MUL
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  fpm_pkg::fpm_data_t     in_data,
  output logic                   out_valid,
  output fpm_pkg::fpm_data_t     out_data
);
  fpm_pkg::fpm_data_t work;
  logic [fpm_pkg::ExpSumW-1:0] exp_adj;

  always_comb begin
    work = in_data;
    exp_adj = in_data.exp_sum;
    unique case (Step)
      fpm_pkg::STEP_MUL: begin
        work.prod = in_data.sig_a * in_data.sig_b;
      end
      fpm_pkg::STEP_NORM: begin
        if (in_data.prod[fpm_pkg::ProdW-1]) begin
          work.frac = in_data.prod[fpm_pkg::ProdW-2 -: fpm_pkg::FracW];
          exp_adj = in_data.exp_sum + fpm_pkg::ExpSumW'(1);
        end else begin
          work.frac = in_data.prod[fpm_pkg::ProdW-3 -: fpm_pkg::FracW];
        end
        work.exp_sum = exp_adj - fpm_pkg::ExpBias;
      end
      default: begin
        work.overflow = 1'b0;
        work.underflow = 1'b0;
        work.product = {in_data.sign, {(fpm_pkg::WordW-1){1'b0}}};
        if (!in_data.zero) begin
          // exp_sum is signed here after bias removal
          if (in_data.exp_sum[fpm_pkg::ExpSumW-1] || in_data.exp_sum == '0) begin
            work.underflow = 1'b1;
          end else if (in_data.exp_sum >= fpm_pkg::ExpLimit) begin
            work.overflow = 1'b1;
            work.product = {in_data.sign, fpm_pkg::ExpMax, {fpm_pkg::FracW{1'b0}}};
          end else begin
            work.product = {in_data.sign, in_data.exp_sum[fpm_pkg::ExpW-1:0], in_data.frac};
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= work;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/float32_multiplier.sv @@
// ----------------------------------------------------------------------------
// float32_multiplier: IEEE-754 binary32 multiplier, truncating
// Three-cell pipeline: significand multiply, normalize, pack and range check.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in      | in  | operand_a[31:0], operand_b[31:0]
//  out     | out | product[31:0], overflow, underflow
//
// One transfer per cycle sustained while results are taken; each item passes
// through the three cell registers. The multiply cell forms one 24x24 product per cycle while the chain advances.
// The chain advances when the last cell is empty or its result is taken.
// Reset clears the valid bits of all cells.
`default_nettype none
module float32_multiplier (
  input wire logic clk,
  input wire logic rst,
  fpm_stream_if.sink   in,
  fpm_stream_if.source out
);
  localparam int unsigned NumCells = fpm_pkg::NumCells;

  fpm_pkg::fpm_data_t cell_data [NumCells+1];
  logic               cell_valid [NumCells+1];
  logic               advance;

  assign advance = !cell_valid[NumCells] || out.ready;
  assign in.ready = advance;

  always_comb begin
    cell_data[0] = '0;
    cell_data[0].sign = in.payload.operand_a[31] ^ in.payload.operand_b[31];
    cell_data[0].zero = (in.payload.operand_a[30:23] == '0)
                      || (in.payload.operand_b[30:23] == '0);
    cell_data[0].exp_sum = fpm_pkg::ExpSumW'(in.payload.operand_a[30:23])
                         + fpm_pkg::ExpSumW'(in.payload.operand_b[30:23]);
    cell_data[0].sig_a = {1'b1, in.payload.operand_a[22:0]};
    cell_data[0].sig_b = {1'b1, in.payload.operand_b[22:0]};
  end
  assign cell_valid[0] = in.valid;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    localparam fpm_pkg::step_t CellStep =
      (i == 0) ? fpm_pkg::STEP_MUL : (i == 1) ? fpm_pkg::STEP_NORM : fpm_pkg::STEP_PACK;
    fpm_cell #(.Step(CellStep)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .in_valid (cell_valid[i]),
      .in_data  (cell_data[i]),
      .out_valid(cell_valid[i+1]),
      .out_data (cell_data[i+1])
    );
  end

  assign out.valid = cell_valid[NumCells];
  assign out.payload.product = cell_data[NumCells].product;
  assign out.payload.overflow = cell_data[NumCells].overflow;
  assign out.payload.underflow = cell_data[NumCells].underflow;
endmodule
`default_nettype wire

@@ hw/rtl/fpm_checker.sv @@
// ----------------------------------------------------------------------------
// fpm_checker: port-level checks for the binary32 multiplier
// Flag exclusivity, flag/product agreement and output hold under stall.
// ----------------------------------------------------------------------------
`default_nettype none
module fpm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_product,
  input wire logic        out_overflow,
  input wire logic        out_underflow
);
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_overflow && out_underflow)) else $error("both flags set");
  a_ovf_inf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_overflow) |-> (out_product[30:0] == 31'h7F80_0000))
    else $error("overflow without infinity");
  a_unf_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_underflow) |-> (out_product[30:0] == '0))
    else $error("underflow without zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_product)))
    else $error("stalled result changed");
endmodule

bind float32_multiplier fpm_checker u_fpm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out.valid),
  .out_ready    (out.ready),
  .out_product  (out.payload.product),
  .out_overflow (out.payload.overflow),
  .out_underflow(out.payload.underflow)
);
`default_nettype wire

@@ sim/tb_float32_multiplier.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_float32_multiplier: self-checking bench for the binary32 multiplier
// Directed corner operands, then random pairs, first without stalls and then under
// random stalls on both channels; every product is predicted from the operands and compared.
// ----------------------------------------------------------------------------
module tb_float32_multiplier;
  localparam int unsigned StallLimit = 2000;

  function automatic fpm_pkg::mul_res_t fmul_predict(logic [31:0] a, logic [31:0] b);
    fpm_pkg::mul_res_t r;
    logic [7:0] ea, eb;
    logic [47:0] sp;
    logic [22:0] frac;
    int         e;
    r = '0;
    ea = a[30:23];
    eb = b[30:23];
    r.product[31] = a[31] ^ b[31];
    if (ea != 0 && eb != 0) begin
      sp = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
      e = int'(ea) + int'(eb) - 127;
      if (sp[47]) begin
        frac = sp[46:24];
        e = e + 1;
      end else begin
        frac = sp[45:23];
      end
      if (e <= 0) begin
        r.underflow = 1'b1;
      end else if (e >= 255) begin
        r.product[30:23] = fpm_pkg::ExpMax;
        r.overflow = 1'b1;
      end else begin
        r.product[30:23] = e[7:0];
        r.product[22:0] = frac;
      end
    end
    return r;
  endfunction

  class product_board;
    fpm_pkg::mul_res_t pending[$];
    int errors = 0;
    int checked = 0;
    int ovf_seen = 0;
    int unf_seen = 0;

    function void note(fpm_pkg::mul_req_t req);
      pending.push_back(fmul_predict(req.operand_a, req.operand_b));
    endfunction

    function void check(fpm_pkg::mul_res_t got);
      fpm_pkg::mul_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h ovf=%b unf=%b", $time,
                 got.product, got.overflow, got.underflow);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.overflow) ovf_seen++;
      if (got.underflow) unf_seen++;
      if (got.product !== want.product) begin
        $display("%0t: product expected %h actual %h", $time, want.product, got.product);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, want.overflow, got.overflow);
        errors++;
      end
      if (got.underflow !== want.underflow) begin
        $display("%0t: underflow expected %b actual %b", $time, want.underflow,
                 got.underflow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   quiet = 1'b0;
  int   stall_cycles = 0;
  int   sent = 0;
  product_board board = new();

  fpm_stream_if #(.payload_t(fpm_pkg::mul_req_t)) in_ch ();
  fpm_stream_if #(.payload_t(fpm_pkg::mul_res_t)) out_ch ();

  float32_multiplier dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch),
    .out(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) board.note(in_ch.payload);
      if (out_ch.valid && out_ch.ready) board.check(out_ch.payload);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (stall_cycles >= StallLimit) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, StallLimit);
      $display("tb_float32_multiplier: errors");
      $finish;
    end
  end

  task automatic send(logic [31:0] a, logic [31:0] b);
    while (!quiet && $urandom_range(99) < 12) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.payload = '{operand_a: a, operand_b: b};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_float(bit near_one);
    logic [31:0] f;
    f = $urandom();
    if (near_one) f[30:23] = 8'($urandom_range(190, 64));
    return f;
  endfunction

  initial begin
    logic [31:0] a, b;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // corners: zeros, subnormals, unity, extremes, inf/nan, range edges
    send(32'h0000_0000, 32'h3F80_0000);
    send(32'h8000_0000, 32'h3F80_0000);
    send(32'h007F_FFFF, 32'h7F7F_FFFF);
    send(32'h3F80_0000, 32'h0000_0001);
    send(32'h3F80_0000, 32'h3F80_0000);
    send(32'hBF80_0000, 32'h3F80_0000);
    send(32'hBF80_0000, 32'hBF80_0000);
    send(32'h3FFF_FFFF, 32'h3FFF_FFFF);
    send(32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send(32'hFF7F_FFFF, 32'h7F7F_FFFF);
    send(32'h0080_0000, 32'h0080_0000);
    send(32'h8080_0000, 32'h0080_0000);
    send(32'h7F80_0000, 32'h3F80_0000);
    send(32'h7FC0_0001, 32'h3F00_0000);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(32'h0080_0000, 32'h3F00_0000);
    send(32'h00FF_FFFF, 32'h3F7F_FFFF);
    send(32'h0080_0000, 32'h3F7F_FFFF);
    send(32'h3F80_0000, 32'h7F7F_FFFF);
    send(32'h3FFF_FFFF, 32'h7F7F_FFFF);
    send(32'h3FFF_FFFF, 32'h7F00_0000);
    send(32'h4000_0000, 32'h7F00_0000);
    send(32'h5555_5555, 32'hAAAA_AAAA);
    drain();

    quiet = 1'b1;
    repeat (300) send(rand_float(1'b1), rand_float(1'b1));
    quiet = 1'b0;
    drain();

    repeat (1000) begin
      a = rand_float($urandom_range(3) != 0);
      b = rand_float($urandom_range(3) != 0);
      if ($urandom_range(19) == 0) a[30:23] = 8'd0;
      if ($urandom_range(19) == 0) b[30:23] = 8'hFF;
      send(a, b);
    end
    drain();
    repeat (10) @(posedge clk);

    $display("ran %0d operand pairs, %0d results checked", sent, board.checked);
    $display("overflow results %0d, underflow results %0d", board.ovf_seen,
             board.unf_seen);
    if (board.errors == 0)
      $display("tb_float32_multiplier: clean");
    else
      $display("tb_float32_multiplier: errors");
    $finish;
  end
endmodule
